[design/at_response_terminator_detect_assert.svh]
// ----------------------------------------------------------------------------
// AT response terminator detect assertion macros
// Shared assertion forms, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef AT_RESPONSE_TERMINATOR_DETECT_ASSERT_SVH
`define AT_RESPONSE_TERMINATOR_DETECT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ATRD_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("at_response_terminator_detect: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ATRD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("at_response_terminator_detect: next-cycle check failed");

`endif

[design/atrd_pkg.sv]
// ----------------------------------------------------------------------------
// AT response terminator detect package
// Widths, item codes, status codes and the terminator key table.
// ----------------------------------------------------------------------------
package atrd_pkg;

    localparam int TIMEOUT_WIDTH = 16;
    localparam int HIST_DEPTH    = 20;
    localparam int HIST_BITS     = HIST_DEPTH * 8;
    localparam int KEY_COUNT     = 6;
    localparam int MIN_BEFORE    = 4;
    localparam int COUNT_W       = $clog2(HIST_DEPTH + 2);

    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_BYTE  = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;

    localparam logic [2:0] STATUS_NONE    = 3'd0;
    localparam logic [2:0] STATUS_TIMEOUT = 3'd7;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    // History vector: byte 0 holds the newest character.
    typedef logic [HIST_BITS-1:0] hist_t;

    // Keys are right aligned so that the last character sits in byte 0.
    localparam hist_t KEY_TEXT [KEY_COUNT] = '{
        hist_t'({"OK", CHAR_CR, CHAR_LF}),
        hist_t'({"ERROR", CHAR_CR, CHAR_LF}),
        hist_t'({"p...", CHAR_CR, CHAR_LF}),
        hist_t'("FAIL"),
        hist_t'("ready"),
        hist_t'({"Y CONNECTED", CHAR_CR, CHAR_LF, CHAR_CR, CHAR_LF, "ERROR"})
    };

    localparam logic [COUNT_W-1:0] KEY_LEN [KEY_COUNT] = '{
        COUNT_W'(4), COUNT_W'(7), COUNT_W'(6), COUNT_W'(4), COUNT_W'(5), COUNT_W'(20)
    };

    typedef struct packed {
        logic [2:0] status;
        logic       finished;
        logic       busy;
    } result_t;

endpackage

[design/atrd_key_match.sv]
// ----------------------------------------------------------------------------
// AT response terminator key matcher
// Compares the history tail against all keys in parallel, first key wins.
// ----------------------------------------------------------------------------
module atrd_key_match (
    input  atrd_pkg::hist_t                 hist,
    input  logic [atrd_pkg::COUNT_W-1:0]    have,
    output logic                            hit,
    output logic [2:0]                      key_code
);
    import atrd_pkg::*;

    logic [KEY_COUNT-1:0] key_hit;

    for (genvar k = 0; k < KEY_COUNT; k++) begin : g_key
        logic [HIST_DEPTH-1:0] byte_ok;
        for (genvar j = 0; j < HIST_DEPTH; j++) begin : g_byte
            assign byte_ok[j] = (COUNT_W'(j) >= KEY_LEN[k]) ||
                                (hist[j*8 +: 8] == KEY_TEXT[k][j*8 +: 8]);
        end
        assign key_hit[k] = (&byte_ok) && (have >= KEY_LEN[k]);
    end

    always_comb
    begin
        key_code = STATUS_NONE;
        for (int k = KEY_COUNT - 1; k >= 0; k--)
        begin
            if (key_hit[k])
            begin
                key_code = 3'(k + 1);
            end
        end
    end

    assign hit = |key_hit;

endmodule

[design/atrd_state.sv]
// ----------------------------------------------------------------------------
// AT response terminator wait state
// Holds the history, byte count, tick counter and status; applies one item.
// ----------------------------------------------------------------------------
module atrd_state (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              step_valid,
    input  logic [1:0]                        kind,
    input  logic [7:0]                        data_byte,
    input  logic [15:0]                       timeout_ms,
    output atrd_pkg::result_t                 result
);
    import atrd_pkg::*;

    hist_t                    hist_reg, hist_next, hist_shift;
    logic [COUNT_W-1:0]       seen_reg, seen_next, have;
    logic [TIMEOUT_WIDTH-1:0] ticks_reg, ticks_next;
    logic                     waiting_reg, waiting_next;
    logic [2:0]               status_reg, status_next;
    logic                     done;
    logic                     hit;
    logic [2:0]               key_code;

    assign hist_shift = {hist_reg[HIST_BITS-9:0], data_byte};
    assign have       = seen_reg + 1'b1;

    atrd_key_match u_match (
        .hist     (hist_shift),
        .have     (have),
        .hit      (hit),
        .key_code (key_code)
    );

    always_comb
    begin
        hist_next    = hist_reg;
        seen_next    = seen_reg;
        ticks_next   = ticks_reg;
        waiting_next = waiting_reg;
        status_next  = status_reg;
        done         = 1'b0;
        case (kind)
            KIND_START:
            begin
                hist_next    = '0;
                seen_next    = '0;
                ticks_next   = TIMEOUT_WIDTH'(timeout_ms);
                waiting_next = 1'b1;
                status_next  = STATUS_NONE;
            end
            KIND_BYTE:
            begin
                if (waiting_reg)
                begin
                    hist_next = hist_shift;
                    if (seen_reg >= COUNT_W'(MIN_BEFORE) && hit)
                    begin
                        status_next  = key_code;
                        waiting_next = 1'b0;
                        done         = 1'b1;
                    end
                    if (seen_reg < COUNT_W'(HIST_DEPTH))
                    begin
                        seen_next = seen_reg + 1'b1;
                    end
                end
            end
            KIND_TICK:
            begin
                if (waiting_reg)
                begin
                    if (ticks_reg != '0)
                    begin
                        ticks_next = ticks_reg - 1'b1;
                    end
                    else
                    begin
                        status_next  = STATUS_TIMEOUT;
                        waiting_next = 1'b0;
                        done         = 1'b1;
                    end
                end
            end
            default:
            begin
                done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg    <= '0;
            seen_reg    <= '0;
            ticks_reg   <= '0;
            waiting_reg <= 1'b0;
            status_reg  <= STATUS_NONE;
        end
        else if (step_valid)
        begin
            hist_reg    <= hist_next;
            seen_reg    <= seen_next;
            ticks_reg   <= ticks_next;
            waiting_reg <= waiting_next;
            status_reg  <= status_next;
        end
    end

    assign result.status   = status_next;
    assign result.finished = done;
    assign result.busy     = waiting_next;

endmodule

[design/at_response_terminator_detect.sv]
// A request passes through an input register and then a result register,
// with the state update between them; the block takes one request per
// cycle, sustained, while the result stream is not back-pressured.
// Reset clears the history, byte count, tick counter, wait flag, status
// and both valid flags; the block takes requests right after reset.
// ----------------------------------------------------------------------------
// AT response terminator detect
// Watches a modem reply stream for six fixed terminators with a tick timeout.
// ----------------------------------------------------------------------------
module at_response_terminator_detect (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // data_byte [7:0], timeout_ms [23:8]
    input  logic [1:0]  s_axis_tuser,   // kind [1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // status [2:0], finished [3], busy_res [4]
);
    import atrd_pkg::*;

    logic        in_valid_reg;
    logic [1:0]  kind_reg;
    logic [7:0]  byte_reg;
    logic [15:0] timeout_reg;
    logic        out_valid_reg;
    result_t     out_data_reg;
    result_t     result;
    logic        out_free;
    logic        step;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            kind_reg    <= s_axis_tuser;
            byte_reg    <= s_axis_tdata[7:0];
            timeout_reg <= s_axis_tdata[23:8];
        end
    end

    atrd_state u_state (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_valid (step),
        .kind       (kind_reg),
        .data_byte  (byte_reg),
        .timeout_ms (timeout_reg),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_data_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_data_reg.busy, out_data_reg.finished,
                            out_data_reg.status};

endmodule

[design/atrd_checker.sv]
// ----------------------------------------------------------------------------
// AT response terminator detect checker
// Port-level checks on the result stream and the input back-pressure.
// ----------------------------------------------------------------------------
`include "at_response_terminator_detect_assert.svh"

module atrd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata
);
    import atrd_pkg::*;

    logic [2:0] out_status;
    logic       out_busy;
    logic       out_ended;
    logic       out_waiting;
    logic       out_stall;

    assign out_status  = m_axis_tdata[2:0];
    assign out_busy    = m_axis_tdata[4];
    assign out_ended   = m_axis_tvalid && m_axis_tdata[3];
    assign out_waiting = m_axis_tvalid && m_axis_tdata[4];
    assign out_stall   = m_axis_tvalid && !m_axis_tready;

    `ATRD_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable(m_axis_tdata))
    `ATRD_ASSERT_SAME(a_finish_idle, out_ended, !out_busy && (out_status != STATUS_NONE))
    `ATRD_ASSERT_SAME(a_busy_no_status, out_waiting, out_status == STATUS_NONE)
    `ATRD_ASSERT_SAME(a_stall_cause, !s_axis_tready, out_stall)

endmodule

bind at_response_terminator_detect atrd_checker u_atrd_checker (.*);
